@@ rtl/core/lpg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared widths, codes and transaction types of the line rasterizer.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 2;

    // Command queue between the front and the back.
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] mag_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    typedef struct packed {
        logic   operation;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } req_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last;
    } pix_t;

    // Classified command: a start carries the prepared line setup.
    typedef struct packed {
        logic   is_start;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        mag_t   abs_dx;
        mag_t   abs_dy;
        logic   step_x_neg;
        logic   step_y_neg;
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/lpg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator front
// Classifies requests and prepares the deltas and step directions of a start.
// ----------------------------------------------------------------------------
module lpg_front (
    input  lpg_pkg::req_t req,
    output lpg_pkg::cmd_t cmd
);
    import lpg_pkg::*;

    logic signed [COORD_BITS:0] sx_w;
    logic signed [COORD_BITS:0] sy_w;
    logic signed [COORD_BITS:0] ex_w;
    logic signed [COORD_BITS:0] ey_w;
    logic signed [COORD_BITS:0] fwd_x;
    logic signed [COORD_BITS:0] rev_x;
    logic signed [COORD_BITS:0] fwd_y;
    logic signed [COORD_BITS:0] rev_y;
    logic                       x_neg;
    logic                       y_neg;

    assign sx_w = {req.start_x[COORD_BITS-1], req.start_x};
    assign sy_w = {req.start_y[COORD_BITS-1], req.start_y};
    assign ex_w = {req.end_x[COORD_BITS-1], req.end_x};
    assign ey_w = {req.end_y[COORD_BITS-1], req.end_y};

    // Both differences are formed in parallel; the direction picks the positive one.
    assign fwd_x = ex_w - sx_w;
    assign rev_x = sx_w - ex_w;
    assign fwd_y = ey_w - sy_w;
    assign rev_y = sy_w - ey_w;

    assign x_neg = !(req.start_x < req.end_x);
    assign y_neg = !(req.start_y < req.end_y);

    always_comb
    begin
        cmd.is_start   = (req.operation == OP_START);
        cmd.start_x    = req.start_x;
        cmd.start_y    = req.start_y;
        cmd.end_x      = req.end_x;
        cmd.end_y      = req.end_y;
        cmd.abs_dx     = x_neg ? rev_x[COORD_BITS-1:0] : fwd_x[COORD_BITS-1:0];
        cmd.abs_dy     = y_neg ? rev_y[COORD_BITS-1:0] : fwd_y[COORD_BITS-1:0];
        cmd.step_x_neg = x_neg;
        cmd.step_y_neg = y_neg;
    end

endmodule
`default_nettype wire

@@ rtl/core/lpg_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator command queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module lpg_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lpg_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          head_valid,
    output lpg_pkg::cmd_t head_cmd,
    input  logic          pop
);
    import lpg_pkg::*;

    cmd_t                  entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_next;
    logic [Q_CNT_BITS-1:0] count_reg;
    logic [Q_CNT_BITS-1:0] count_next;

    assign full       = (count_reg == Q_CNT_BITS'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_BITS'(Q_DEPTH))
        else $error("queue occupancy beyond its depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy did not follow a lone write");

endmodule
`default_nettype wire

@@ rtl/core/lpg_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator back
// Holds the line state, loads it on a start, advances one Bresenham step
// per next command of an active line and registers the resulting pixel.
// ----------------------------------------------------------------------------
module lpg_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  lpg_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          pix_valid,
    input  logic          pix_stall,
    output lpg_pkg::pix_t pix
);
    import lpg_pkg::*;

    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t tgt_x_reg, tgt_x_next;
    coord_t tgt_y_reg, tgt_y_next;
    mag_t   abs_dx_reg, abs_dx_next;
    mag_t   abs_dy_reg, abs_dy_next;
    logic   step_x_neg_reg, step_x_neg_next;
    logic   step_y_neg_reg, step_y_neg_next;
    err_t   err_reg, err_next;
    logic   active_reg, active_next;
    logic   out_valid_reg, out_valid_next;
    pix_t   out_reg, out_next;

    logic                     take;
    logic signed [ERR_BITS:0] e_w;
    logic signed [ERR_BITS:0] dx_w;
    logic signed [ERR_BITS:0] dy_w;
    logic signed [ERR_BITS:0] sub_w;
    logic signed [ERR_BITS:0] add_w;
    logic signed [ERR_BITS:0] sum_w;
    logic                     move_x;
    logic                     move_y;
    coord_t                   inc_x;
    coord_t                   inc_y;
    coord_t                   nx;
    coord_t                   ny;
    mag_t                     half_dx;
    mag_t                     half_dy;
    err_t                     init_err;
    logic                     emit;
    logic                     fin;

    assign take    = cmd_valid && (!out_valid_reg || !pix_stall);
    assign cmd_pop = take;

    // Error step: x moves while e > -dx, y moves while e < dy.
    assign e_w    = {err_reg[ERR_BITS-1], err_reg};
    assign dx_w   = $signed({{(ERR_BITS + 1 - COORD_BITS){1'b0}}, abs_dx_reg});
    assign dy_w   = $signed({{(ERR_BITS + 1 - COORD_BITS){1'b0}}, abs_dy_reg});
    assign move_x = (e_w > -dx_w);
    assign move_y = (e_w < dy_w);
    assign sub_w  = move_x ? dy_w : '0;
    assign add_w  = move_y ? dx_w : '0;
    assign sum_w  = e_w - sub_w + add_w;

    assign inc_x = move_x ? (step_x_neg_reg ? '1 : COORD_BITS'(1)) : '0;
    assign inc_y = move_y ? (step_y_neg_reg ? '1 : COORD_BITS'(1)) : '0;
    assign nx    = cur_x_reg + inc_x;
    assign ny    = cur_y_reg + inc_y;

    // Initial error is half the major delta, negative when y dominates or the deltas are equal.
    assign half_dx  = cmd.abs_dx >> 1;
    assign half_dy  = cmd.abs_dy >> 1;
    assign init_err = (cmd.abs_dx > cmd.abs_dy) ? err_t'(half_dx)
                                                : -$signed(err_t'(half_dy));

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        tgt_x_next      = tgt_x_reg;
        tgt_y_next      = tgt_y_reg;
        abs_dx_next     = abs_dx_reg;
        abs_dy_next     = abs_dy_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        err_next        = err_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        emit            = 1'b0;
        fin             = 1'b0;

        if (take)
        begin
            if (cmd.is_start)
            begin
                cur_x_next      = cmd.start_x;
                cur_y_next      = cmd.start_y;
                tgt_x_next      = cmd.end_x;
                tgt_y_next      = cmd.end_y;
                abs_dx_next     = cmd.abs_dx;
                abs_dy_next     = cmd.abs_dy;
                step_x_neg_next = cmd.step_x_neg;
                step_y_neg_next = cmd.step_y_neg;
                err_next        = init_err;
                fin             = (cmd.start_x == cmd.end_x) && (cmd.start_y == cmd.end_y);
                emit            = 1'b1;
            end
            else if (active_reg)
            begin
                cur_x_next = nx;
                cur_y_next = ny;
                err_next   = sum_w[ERR_BITS-1:0];
                fin        = (nx == tgt_x_reg) && (ny == tgt_y_reg);
                emit       = 1'b1;
            end

            if (emit)
            begin
                active_next      = !fin;
                out_next.pixel_x = cur_x_next;
                out_next.pixel_y = cur_y_next;
                out_next.last    = fin;
            end
            out_valid_next = emit;
        end
        else if (!pix_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            tgt_x_reg      <= '0;
            tgt_y_reg      <= '0;
            abs_dx_reg     <= '0;
            abs_dy_reg     <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            err_reg        <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            tgt_x_reg      <= tgt_x_next;
            tgt_y_reg      <= tgt_y_next;
            abs_dx_reg     <= abs_dx_next;
            abs_dy_reg     <= abs_dy_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            err_reg        <= err_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit && fin) |=> !active_reg)
        else $error("line still active after its last pixel");

    a_idle_next_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !cmd.is_start && !active_reg) |=> !pix_valid)
        else $error("pixel produced with no line in progress");

    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.is_start) |=> (pix_valid && pix.pixel_x == $past(cmd.start_x)
                                    && pix.pixel_y == $past(cmd.start_y)))
        else $error("start did not produce its first pixel");

endmodule
`default_nettype wire

@@ rtl/core/line_pixel_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator
// All-octant Bresenham line rasterizer with a decoupled front and back.
//
//   Channel | Signals                  | Transaction
//   --------+--------------------------+--------------------------------------
//   request | req_valid, req_stall, req| start a line, or ask for next pixel
//   pixel   | pix_valid, pix_stall, pix| one pixel with its last flag
//
// One request per cycle is sustained while pix_stall is low; the pixel of a
// request is registered in the queue entry, then in the output register of
// the back. The combinational Bresenham step in the back sets that rate.
// Reset clears the line state; no line is active after reset.
// req_stall rises only when the two-entry command queue is full, as requests
// keep arriving while pix_stall holds a waiting pixel.
// ----------------------------------------------------------------------------
module line_pixel_generator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lpg_pkg::req_t req,
    output logic          pix_valid,
    input  logic          pix_stall,
    output lpg_pkg::pix_t pix
);
    import lpg_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic head_valid;
    logic head_pop;

    assign req_stall = q_full;

    lpg_front u_front (
        .req (req),
        .cmd (front_cmd)
    );

    lpg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (req_valid && !q_full),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (head_pop)
    );

    lpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (head_pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule
`default_nettype wire
